@@ design/idca_pkg.sv @@
package idca_pkg;

  // default width of the number as read
  localparam int unsigned ValueWidthDef = 32;
  // width of the value port, fixed
  localparam int unsigned InWidth       = 32;
  localparam int unsigned CodeWidth     = 8;
  localparam int unsigned CountWidth    = 31;
  localparam logic [CountWidth-1:0] CountMax = 31'h7FFF_FFFF;

  // entries in the queue between front and back
  localparam int unsigned QueueDepth = 2;

  localparam logic [CodeWidth-1:0] CharMinus = 8'h2D;
  localparam logic [CodeWidth-1:0] CharZero  = 8'h30;
  localparam logic [CodeWidth-1:0] CharNine  = 8'h39;

  // handshake and classification between stages
  typedef struct packed {
    logic valid;
    logic neg;
  } item_ctl_t;

  // magnitude bits actually carried: the value port holds 32 bits at most
  function automatic int unsigned mag_width(input int unsigned w);
    return (w < InWidth) ? w : InWidth;
  endfunction

  // decimal digits needed for the largest magnitude, floor(w * log10(2)) + 1
  function automatic int unsigned num_digits(input int unsigned w);
    return (mag_width(w) * 30103) / 100000 + 1;
  endfunction

  // converter steps, four binary bits per step
  function automatic int unsigned num_steps(input int unsigned w);
    return (mag_width(w) + 3) / 4;
  endfunction

endpackage

@@ design/idca_front.sv @@
module idca_front #(
  parameter int unsigned VALUE_WIDTH = idca_pkg::ValueWidthDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  logic [idca_pkg::InWidth-1:0]                 value_bits_i,
  input  logic                                         mode_i,
  output idca_pkg::item_ctl_t                          q_ctl_o,
  output logic [idca_pkg::mag_width(VALUE_WIDTH)-1:0]  q_mag_o,
  input  logic                                         q_pop_i
);
  import idca_pkg::*;

  localparam int unsigned MagW  = mag_width(VALUE_WIDTH);
  localparam int unsigned PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam bit          HasSign = (VALUE_WIDTH <= InWidth);

  logic [MagW-1:0] raw_w;
  logic [MagW-1:0] mag_w;
  logic            neg_w;
  logic            push_w;
  logic            pop_w;

  logic [MagW:0]   mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // classify: sign only exists when the width fits the port
  assign raw_w = value_bits_i[MagW-1:0];
  assign neg_w = mode_i & HasSign & raw_w[MagW-1];
  assign mag_w = neg_w ? (~raw_w + {{(MagW-1){1'b0}}, 1'b1}) : raw_w;

  assign in_stall_o = (cnt_q == CntW'(QueueDepth));
  assign push_w     = in_valid_i & ~in_stall_o;
  assign pop_w      = q_ctl_o.valid & q_pop_i;

  assign q_ctl_o.valid = (cnt_q != '0);
  assign q_ctl_o.neg   = mem_q[rd_ptr_q][MagW];
  assign q_mag_o       = mem_q[rd_ptr_q][MagW-1:0];

  // queue pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_w) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_w) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_w && !pop_w) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_w && pop_w) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_w) begin
      mem_q[wr_ptr_q] <= {neg_w, mag_w};
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("queue fill level beyond depth");
`endif

endmodule

@@ design/idca_convert.sv @@
module idca_convert #(
  parameter int unsigned VALUE_WIDTH = idca_pkg::ValueWidthDef
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  idca_pkg::item_ctl_t                             q_ctl_i,
  input  logic [idca_pkg::mag_width(VALUE_WIDTH)-1:0]     q_mag_i,
  output logic                                            q_pop_o,
  output idca_pkg::item_ctl_t                             res_ctl_o,
  output logic [4*idca_pkg::num_digits(VALUE_WIDTH)-1:0]  res_bcd_o,
  input  logic                                            res_take_i
);
  import idca_pkg::*;

  localparam int unsigned MagW   = mag_width(VALUE_WIDTH);
  localparam int unsigned NumDig = num_digits(VALUE_WIDTH);
  localparam int unsigned Steps  = num_steps(VALUE_WIDTH);
  localparam int unsigned PadW   = 4 * Steps;
  localparam int unsigned BcdW   = 4 * NumDig;
  localparam int unsigned StepW  = (Steps > 1) ? $clog2(Steps) : 1;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StBusy = 3'b010,
    StDone = 3'b100
  } conv_state_e;

  conv_state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [PadW-1:0]  bin_q, bin_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic             neg_q, neg_d;
  logic [PadW-1:0]  bin_s;
  logic [BcdW-1:0]  bcd_s;

  // four shift-and-add-three rounds per step
  always_comb begin
    bin_s = bin_q;
    bcd_s = bcd_q;
    for (int b = 0; b < 4; b++) begin
      for (int d = 0; d < NumDig; d++) begin
        if (bcd_s[d*4 +: 4] >= 4'd5) begin
          bcd_s[d*4 +: 4] = bcd_s[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_s, bin_s} = {bcd_s[BcdW-2:0], bin_s, 1'b0};
    end
  end

  assign q_pop_o         = (state_q == StIdle) & q_ctl_i.valid;
  assign res_ctl_o.valid = (state_q == StDone);
  assign res_ctl_o.neg   = neg_q;
  assign res_bcd_o       = bcd_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    unique case (state_q)
      StIdle: begin
        if (q_ctl_i.valid) begin
          bin_d   = PadW'(q_mag_i);
          bcd_d   = '0;
          neg_d   = q_ctl_i.neg;
          step_d  = StepW'(Steps - 1);
          state_d = StBusy;
        end
      end
      StBusy: begin
        bin_d = bin_s;
        bcd_d = bcd_s;
        if (step_q == '0) begin
          state_d = StDone;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      StDone: begin
        if (res_take_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) && !$past(state_q == StDone) |-> $past(state_q == StBusy))
    else $error("conversion finished without running its steps");
`endif

endmodule

@@ design/idca_emit.sv @@
module idca_emit #(
  parameter int unsigned VALUE_WIDTH = idca_pkg::ValueWidthDef
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  idca_pkg::item_ctl_t                             res_ctl_i,
  input  logic [4*idca_pkg::num_digits(VALUE_WIDTH)-1:0]  res_bcd_i,
  output logic                                            res_take_o,
  output logic                                            out_valid_o,
  input  logic                                            out_stall_i,
  output logic [idca_pkg::CodeWidth-1:0]                  char_code_o,
  output logic                                            last_o,
  output logic [idca_pkg::CountWidth-1:0]                 char_total_o
);
  import idca_pkg::*;

  localparam int unsigned NumDig = num_digits(VALUE_WIDTH);
  localparam int unsigned IdxW   = $clog2(NumDig);

  logic [NumDig-1:0][3:0]   bcd_q, bcd_d;
  logic [NumDig-1:0][3:0]   in_dig_w;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [IdxW-1:0]          top_w;
  logic                     busy_q, busy_d;
  logic                     sign_q, sign_d;
  logic                     out_valid_q, out_valid_d;
  logic [CodeWidth-1:0]     char_q, char_d;
  logic                     last_q, last_d;
  logic [CountWidth-1:0]    count_q, count_d;
  logic                     adv_w;

  assign in_dig_w = res_bcd_i;

  // most significant non-zero digit, digit zero when the value is zero
  always_comb begin
    top_w = '0;
    for (int i = 0; i < NumDig; i++) begin
      if (in_dig_w[i] != 4'd0) begin
        top_w = IdxW'(i);
      end
    end
  end

  // output register free or being emptied this cycle
  assign adv_w      = ~out_valid_q | ~out_stall_i;
  assign res_take_o = ~busy_q & res_ctl_i.valid;

  // character sequencer
  always_comb begin
    bcd_d       = bcd_q;
    idx_d       = idx_q;
    busy_d      = busy_q;
    sign_d      = sign_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    count_d     = count_q;
    if (!busy_q) begin
      if (adv_w) begin
        out_valid_d = 1'b0;
      end
      if (res_ctl_i.valid) begin
        bcd_d  = in_dig_w;
        idx_d  = top_w;
        sign_d = res_ctl_i.neg;
        busy_d = 1'b1;
      end
    end else if (adv_w) begin
      out_valid_d = 1'b1;
      count_d     = (count_q == CountMax) ? count_q : count_q + CountWidth'(1);
      if (sign_q) begin
        char_d = CharMinus;
        last_d = 1'b0;
        sign_d = 1'b0;
      end else begin
        char_d = CharZero + {4'd0, bcd_q[idx_q]};
        last_d = (idx_q == '0);
        if (idx_q == '0) begin
          busy_d = 1'b0;
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      sign_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      sign_q      <= sign_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign char_code_o  = char_q;
  assign last_o       = last_q;
  assign char_total_o = count_q;

`ifndef SYNTHESIS
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (char_q == CharMinus) ||
                    ((char_q >= CharZero) && (char_q <= CharNine)))
    else $error("character outside minus and digits");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (char_q == CharMinus) |-> !last_q)
    else $error("minus sign flagged as final character");

  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (count_q != '0))
    else $error("character shown with zero running total");
`endif

endmodule

@@ design/integer_to_decimal_ascii.sv @@
// integer to decimal ascii printer
//
// input channel: in_valid_i / in_stall_o carry value_bits_i and mode_i
// (0 unsigned, 1 signed two's complement of VALUE_WIDTH bits). output
// channel: out_valid_o / out_stall_i carry one character per transaction,
// char_code_o ('-' or '0'..'9', most significant first, no leading zeros),
// last_o on the final character and char_total_o, the saturating count of
// characters emitted so far including this one.
// a transaction moves when valid is high and stall is low.
// the front classifies and negates into a two-entry queue; the converter
// turns the magnitude into bcd at four bits a cycle while the emitter
// prints the previous number, one character a cycle while the receiver
// does not stall.
// reset clears the queue, the sequencers and the running total to zero.
// a stalled receiver holds the output register and, once the queue fills,
// stalls the input; nothing is lost.
module integer_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = idca_pkg::ValueWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [idca_pkg::InWidth-1:0]     value_bits_i,
  input  logic                             mode_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [idca_pkg::CodeWidth-1:0]   char_code_o,
  output logic                             last_o,
  output logic [idca_pkg::CountWidth-1:0]  char_total_o
);
  import idca_pkg::*;

  localparam int unsigned MagW = mag_width(VALUE_WIDTH);
  localparam int unsigned BcdW = 4 * num_digits(VALUE_WIDTH);

  item_ctl_t       q_ctl;
  logic [MagW-1:0] q_mag;
  logic            q_pop;
  item_ctl_t       res_ctl;
  logic [BcdW-1:0] res_bcd;
  logic            res_take;

  // accept and classify
  idca_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_bits_i (value_bits_i),
    .mode_i       (mode_i),
    .q_ctl_o      (q_ctl),
    .q_mag_o      (q_mag),
    .q_pop_i      (q_pop)
  );

  // binary to bcd
  idca_convert #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_convert (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_ctl_i    (q_ctl),
    .q_mag_i    (q_mag),
    .q_pop_o    (q_pop),
    .res_ctl_o  (res_ctl),
    .res_bcd_o  (res_bcd),
    .res_take_i (res_take)
  );

  // character output
  idca_emit #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_ctl_i    (res_ctl),
    .res_bcd_i    (res_bcd),
    .res_take_o   (res_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_code_o  (char_code_o),
    .last_o       (last_o),
    .char_total_o (char_total_o)
  );

endmodule
